// ===== rtl/core/rc5_pkg.sv =====
// Shared types, constants and helper functions for the RC5 cipher engine.
// No dependencies; used by the key cell, the mix unit and the top level of the engine.
`default_nettype none
package rc5_pkg;

  localparam logic [31:0] MAGIC_P = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;
  localparam logic [4:0]  EXP_ROT = 5'd3;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_INIT,
    RING_FWD,
    RING_BWD
  } ring_op_t;

  typedef enum logic [3:0] {
    MOP_HOLD,
    MOP_KEY_INIT,
    MOP_EXPAND,
    MOP_LOAD,
    MOP_ENC_WHITEN,
    MOP_ENC_A,
    MOP_ENC_B,
    MOP_DEC_B,
    MOP_DEC_A,
    MOP_DEC_WHITEN
  } mix_op_t;

  typedef struct packed {
    mix_op_t  mix_op;
    ring_op_t ring_op;
    logic     kw_sel;
  } ctl_t;

  function automatic logic [31:0] init_key(input int unsigned idx);
    return MAGIC_P + MAGIC_Q * 32'(idx);
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} >> n;
    return t[31:0];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rc5_key_cell.sv =====
// One subkey cell of the rotating subkey ring.
// Depends on rc5_pkg for the ring operation type.
`default_nettype none
module rc5_key_cell #(
  parameter logic [31:0] INIT_VALUE = 32'h0
) (
  input  wire logic              clk,
  input  wire rc5_pkg::ring_op_t ring_op,
  input  wire logic [31:0]       fwd_src,
  input  wire logic [31:0]       bwd_src,
  output logic [31:0]            key_q
);
  import rc5_pkg::*;

  logic [31:0] key_r;

  always_ff @(posedge clk) begin
    case (ring_op)
      RING_INIT: key_r <= INIT_VALUE;
      RING_FWD:  key_r <= fwd_src;
      RING_BWD:  key_r <= bwd_src;
      default:   key_r <= key_r;
    endcase
  end

  assign key_q = key_r;

endmodule
`default_nettype wire

// ===== rtl/core/rc5_mix_unit.sv =====
// Working registers of the engine: key mixing accumulators, key words and
// the two data words, with the half-round logic. Depends on rc5_pkg.
`default_nettype none
module rc5_mix_unit (
  input  wire logic          clk,
  input  wire rc5_pkg::ctl_t ctl,
  input  wire logic [63:0]   cipher_key,
  input  wire logic [63:0]   data_block,
  input  wire logic [31:0]   key_head,
  input  wire logic [31:0]   key_next,
  input  wire logic [31:0]   key_tail,
  output logic [31:0]        word_a,
  output logic [31:0]        word_b,
  output logic [31:0]        mix_new
);
  import rc5_pkg::*;

  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] kw_r [2];
  logic [31:0] kw_nxt [2];
  logic [31:0] exp_a, exp_b;

  always_comb begin
    exp_a = rotl32(key_head + a_r + b_r, EXP_ROT);
    exp_b = rotl32(kw_r[ctl.kw_sel] + exp_a + b_r, exp_a[4:0] + b_r[4:0]);
    a_nxt = a_r;
    b_nxt = b_r;
    kw_nxt[0] = kw_r[0];
    kw_nxt[1] = kw_r[1];
    case (ctl.mix_op)
      MOP_KEY_INIT: begin
        a_nxt = '0;
        b_nxt = '0;
        kw_nxt[0] = cipher_key[63:32];
        kw_nxt[1] = cipher_key[31:0];
      end
      MOP_EXPAND: begin
        a_nxt = exp_a;
        b_nxt = exp_b;
        kw_nxt[ctl.kw_sel] = exp_b;
      end
      MOP_LOAD: begin
        a_nxt = data_block[31:0];
        b_nxt = data_block[63:32];
      end
      MOP_ENC_WHITEN: begin
        a_nxt = a_r + key_head;
        b_nxt = b_r + key_next;
      end
      MOP_ENC_A: a_nxt = rotl32(a_r ^ b_r, b_r[4:0]) + key_head;
      MOP_ENC_B: b_nxt = rotl32(b_r ^ a_r, a_r[4:0]) + key_head;
      MOP_DEC_B: b_nxt = rotr32(b_r - key_tail, a_r[4:0]) ^ a_r;
      MOP_DEC_A: a_nxt = rotr32(a_r - key_tail, b_r[4:0]) ^ b_r;
      MOP_DEC_WHITEN: begin
        a_nxt = a_r - key_head;
        b_nxt = b_r - key_next;
      end
      default: begin
        a_nxt = a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    kw_r[0] <= kw_nxt[0];
    kw_r[1] <= kw_nxt[1];
  end

  assign word_a  = a_r;
  assign word_b  = b_r;
  assign mix_new = exp_a;

endmodule
`default_nettype wire

// ===== rtl/core/rc5_block_cipher_engine.sv =====
// Top level of the RC5-32 block cipher engine: sequencer, subkey ring and
// output register. Depends on rc5_pkg, rc5_key_cell and rc5_mix_unit.
//
// One block is processed at a time. The subkeys live in a ring of
// 2*ROUND_COUNT+2 cells that rotates one position per cycle, and one
// half-round is computed per cycle against the ring head (encrypt) or tail
// (decrypt). After reset and after each key write, the first block first
// expands the key before it is loaded. A new block is accepted as soon as
// the previous one has moved into the output register.
`default_nettype none
module rc5_block_cipher_engine #(
  parameter int ROUND_COUNT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [63:0] cfg_cipher_key,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [63:0] in_data_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_result_block
);
  import rc5_pkg::*;

  localparam int TABLE_LEN = 2 * ROUND_COUNT + 2;
  localparam int CNT_W     = $clog2(3 * TABLE_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KINIT,
    S_EXPAND,
    S_LOAD,
    S_PRE,
    S_ROUND,
    S_POST,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [CNT_W-1:0] cnt_r;
  logic        keys_ready_r;
  logic [63:0] key_r;
  logic        op_r;
  logic [63:0] data_r;
  logic        out_valid_r;
  logic [63:0] out_block_r;

  ctl_t        ctl;
  logic [31:0] ring_q [TABLE_LEN];
  logic [31:0] tail_in;
  logic [31:0] word_a, word_b, mix_new;
  logic        in_accept;
  logic        pre_last, post_last;

  assign in_accept = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign pre_last  = !op_r || (cnt_r == CNT_W'(1));
  assign post_last = op_r || (cnt_r == CNT_W'(1));

  always_comb begin
    ctl.mix_op  = MOP_HOLD;
    ctl.ring_op = RING_HOLD;
    ctl.kw_sel  = cnt_r[0];
    case (state_r)
      S_KINIT: begin
        ctl.mix_op  = MOP_KEY_INIT;
        ctl.ring_op = RING_INIT;
      end
      S_EXPAND: begin
        ctl.mix_op  = MOP_EXPAND;
        ctl.ring_op = RING_FWD;
      end
      S_LOAD: ctl.mix_op = MOP_LOAD;
      S_PRE: begin
        ctl.mix_op  = op_r ? MOP_HOLD : MOP_ENC_WHITEN;
        ctl.ring_op = op_r ? RING_BWD : RING_HOLD;
      end
      S_ROUND: begin
        if (op_r) begin
          ctl.mix_op  = cnt_r[0] ? MOP_DEC_A : MOP_DEC_B;
          ctl.ring_op = RING_BWD;
        end else begin
          ctl.mix_op  = cnt_r[0] ? MOP_ENC_B : MOP_ENC_A;
          ctl.ring_op = RING_FWD;
        end
      end
      S_POST: begin
        ctl.mix_op  = op_r ? MOP_DEC_WHITEN : MOP_HOLD;
        ctl.ring_op = op_r ? RING_HOLD : RING_FWD;
      end
      default: begin
        ctl.mix_op = MOP_HOLD;
      end
    endcase
  end

  assign tail_in = (state_r == S_EXPAND) ? mix_new : ring_q[0];

  for (genvar i = 0; i < TABLE_LEN; i++) begin : g_ring
    rc5_key_cell #(
      .INIT_VALUE(init_key(i))
    ) u_cell (
      .clk    (clk),
      .ring_op(ctl.ring_op),
      .fwd_src((i == TABLE_LEN - 1) ? tail_in : ring_q[(i + 1) % TABLE_LEN]),
      .bwd_src(ring_q[(i + TABLE_LEN - 1) % TABLE_LEN]),
      .key_q  (ring_q[i])
    );
  end

  rc5_mix_unit u_mix (
    .clk       (clk),
    .ctl       (ctl),
    .cipher_key(key_r),
    .data_block(data_r),
    .key_head  (ring_q[0]),
    .key_next  (ring_q[1]),
    .key_tail  (ring_q[TABLE_LEN-1]),
    .word_a    (word_a),
    .word_b    (word_b),
    .mix_new   (mix_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      key_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        out_block_r <= {bswap32(word_b), bswap32(word_a)};
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        key_r        <= cfg_cipher_key;
        keys_ready_r <= 1'b0;
      end else if ((state_r == S_EXPAND) && (cnt_r == CNT_W'(3 * TABLE_LEN - 1))) begin
        keys_ready_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            op_r    <= in_operation;
            data_r  <= in_data_block;
            cnt_r   <= '0;
            state_r <= keys_ready_r ? S_LOAD : S_KINIT;
          end
        end
        S_KINIT: begin
          cnt_r   <= '0;
          state_r <= S_EXPAND;
        end
        S_EXPAND: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(3 * TABLE_LEN - 1)) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= S_PRE;
        end
        S_PRE: begin
          if (pre_last) begin
            cnt_r   <= '0;
            state_r <= S_ROUND;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_ROUND: begin
          if (cnt_r == CNT_W'(2 * ROUND_COUNT - 1)) begin
            cnt_r   <= '0;
            state_r <= S_POST;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_POST: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (post_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;

endmodule
`default_nettype wire

// ===== rtl/core/rc5_chk.sv =====
// Port-level checker for the RC5 cipher engine, bound to the top level.
// Depends only on the ports of rc5_block_cipher_engine.
`default_nettype none
module rc5_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_result_block
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("engine did not go busy after an input transaction");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_block))
    else $error("stalled result changed");

endmodule

bind rc5_block_cipher_engine rc5_chk u_chk (.*);
`default_nettype wire

// ===== dv/rc5_block_cipher_engine_test.sv =====
// Self-checking testbench for the RC5-32 block cipher engine: drives blocks
// under random idling and checks every result against a cipher predictor.
// Depends only on rc5_block_cipher_engine.
`default_nettype none
module rc5_block_cipher_engine_test;

  localparam int ROUNDS = 10;
  localparam int SUBKEYS = 2 * ROUNDS + 2;
  localparam logic [31:0] SEED_P = 32'hb7e15163;
  localparam logic [31:0] STEP_Q = 32'h9e3779b9;
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [63:0] cfg_cipher_key = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [63:0] in_data_block = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_result_block;

  logic [63:0] active_key = '0;
  logic [31:0] subkeys[SUBKEYS];
  logic subkeys_valid = 1'b0;
  logic [63:0] pending_blocks[$];
  int error_count = 0;
  int hold_off_cycles = 0;
  int stall_mode = 0;

  rc5_block_cipher_engine #(.ROUND_COUNT(ROUNDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_cipher_key(cfg_cipher_key),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_data_block(in_data_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_block(out_result_block)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol(logic [31:0] v, logic [4:0] n);
    return (n == 0) ? v : ((v << n) | (v >> (6'd32 - n)));
  endfunction

  function automatic logic [31:0] ror(logic [31:0] v, logic [4:0] n);
    return (n == 0) ? v : ((v >> n) | (v << (6'd32 - n)));
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  task automatic expand_subkeys();
    logic [31:0] kw[2];
    logic [31:0] sa, sb;
    kw[0] = active_key[63:32];
    kw[1] = active_key[31:0];
    subkeys[0] = SEED_P;
    for (int s = 1; s < SUBKEYS; s++) subkeys[s] = subkeys[s - 1] + STEP_Q;
    sa = '0;
    sb = '0;
    for (int s = 0; s < 3 * SUBKEYS; s++) begin
      sa = rol(subkeys[s % SUBKEYS] + sa + sb, 5'd3);
      subkeys[s % SUBKEYS] = sa;
      sb = rol(kw[s & 1] + sa + sb, 5'(sa + sb));
      kw[s & 1] = sb;
    end
    subkeys_valid = 1'b1;
  endtask

  task automatic predict_block(logic op, logic [63:0] blk);
    logic [31:0] a, b;
    a = blk[31:0];
    b = blk[63:32];
    if (!subkeys_valid) expand_subkeys();
    if (op == OP_ENCRYPT) begin
      a += subkeys[0];
      b += subkeys[1];
      for (int r = 0; r < ROUNDS; r++) begin
        a = rol(a ^ b, b[4:0]) + subkeys[2 * r];
        b = rol(b ^ a, a[4:0]) + subkeys[2 * r + 1];
      end
    end else begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        b = ror(b - subkeys[2 * r + 1], a[4:0]) ^ a;
        a = ror(a - subkeys[2 * r], b[4:0]) ^ b;
      end
      a -= subkeys[0];
      b -= subkeys[1];
    end
    pending_blocks.insert(pending_blocks.size(), {swap_bytes(b), swap_bytes(a)});
  endtask

  task automatic send_block(logic op, logic [63:0] blk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_block <= blk;
    do @(posedge clk); while (in_stall);
    predict_block(op, blk);
    if ($urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(logic [63:0] key);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_cipher_key <= key;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    active_key = key;
    subkeys_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_result_block);
        error_count++;
      end else begin
        if (out_result_block !== pending_blocks[0]) begin
          $display("%0t: result expected %h actual %h", $time,
                   pending_blocks[0], out_result_block);
          error_count++;
        end
        void'(pending_blocks.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        default: out_stall <= ($urandom_range(1) == 0);
      endcase
    end
  end

  task automatic test_zero_key();
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
  endtask

  task automatic test_key_extremes();
    write_key('1);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, 64'h8000_0000_0000_0001);
    write_key(64'h0);
    send_block(OP_DECRYPT, 64'h0123_4567_89ab_cdef);
    write_key(64'h0123_4567_89ab_cdef);
    send_block(OP_ENCRYPT, 64'hfedc_ba98_7654_3210);
    send_block(OP_DECRYPT, 64'hfedc_ba98_7654_3210);
  endtask

  task automatic test_round_trip();
    logic [63:0] blk;
    write_key(rand64());
    for (int i = 0; i < 6; i++) begin
      blk = rand64();
      send_block(OP_ENCRYPT, blk);
      send_block(OP_DECRYPT, blk);
    end
  endtask

  task automatic test_random_blocks();
    for (int phase = 0; phase < 6; phase++) begin
      stall_mode = phase % 3;
      write_key(phase == 5 ? '1 : rand64());
      for (int i = 0; i < 70; i++) send_block(1'($urandom_range(1)), rand64());
    end
  endtask

  task automatic test_back_pressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 10; i++) send_block(1'($urandom_range(1)), rand64());
    wait_drained();
    for (int i = 0; i < 5; i++) send_block(OP_ENCRYPT, rand64());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_key();
    test_key_extremes();
    test_round_trip();
    test_random_blocks();
    test_back_pressure();
    wait_drained();
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
